// File: sv/mrwt_pkg.sv
// Shared verdict codes for the Miller-Rabin witness test.
`timescale 1ns / 1ps
package mrwt_pkg;
  localparam logic [1:0] VERDICT_PRIME   = 2'd0;
  localparam logic [1:0] VERDICT_ROOT    = 2'd1;
  localparam logic [1:0] VERDICT_FERMAT  = 2'd2;
  localparam logic [1:0] VERDICT_INVALID = 2'd3;
endpackage

// File: sv/mrwt_cell.sv
// One registered step of interleaved modular multiplication: r' = (2r + b*y) mod n.
`timescale 1ns / 1ps
module mrwt_cell #(
  parameter int WIDTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [WIDTH-1:0] acc_i,
  input  logic             bit_i,
  input  logic [WIDTH-1:0] mcand_i,
  input  logic [WIDTH-1:0] mod_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] acc_o
);
  logic [WIDTH+1:0] sum;
  logic [WIDTH+1:0] red1;
  logic [WIDTH+1:0] red2;
  logic [WIDTH+1:0] mod_ext;
  logic             valid_q, valid_d;
  logic [WIDTH-1:0] acc_q, acc_d;

  assign mod_ext = {2'b00, mod_i};

  always_comb begin
    sum     = {1'b0, acc_i, 1'b0} + (bit_i ? {2'b00, mcand_i} : '0);
    red1    = (sum >= mod_ext) ? sum - mod_ext : sum;
    red2    = (red1 >= mod_ext) ? red1 - mod_ext : red1;
    acc_d   = red2[WIDTH-1:0];
    valid_d = valid_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign valid_o = valid_q;
  assign acc_o   = acc_q;
endmodule

// File: sv/miller_rabin_witness_test.sv
// Top level: Miller-Rabin witness test on a row of modular-multiply cells.
//
// Input channel (in_valid_i/in_ready_o) transfers modulus, base and exponent.
// Output channel (out_valid_o/out_ready_i) transfers verdict and residue,
// one result per input item, in order.
// Each modular product runs through a row of WIDTH registered cells, one
// multiplier bit per cell. An item needs one product to reduce the base,
// then per exponent bit one squaring and, for a set bit, one multiply; a
// nontrivial square root of one found on the way stops the item early. A
// modulus below two skips the products and ends with the invalid verdict.
// One item is worked on at a time; in_ready_o is high only when the
// sequencer is idle. The result sits in an output register, so a new item
// is taken while a result waits; a finished item waits for that register
// if the receiver stalls.
// Reset clears the sequencer, the cell valid bits and the output valid.
`timescale 1ns / 1ps
module miller_rabin_witness_test #(
  parameter int WIDTH    = 16,
  parameter int EXP_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [WIDTH-1:0]    modulus_i,
  input  logic [WIDTH-1:0]    base_i,
  input  logic [EXP_BITS-1:0] exponent_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          verdict_o,
  output logic [WIDTH-1:0]    residue_o
);
  localparam int CW = (EXP_BITS > 1) ? $clog2(EXP_BITS) : 1;
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RED  = 3'd1;
  localparam logic [2:0] ST_SQ   = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0]          state_q, state_d;
  logic                issued_q, issued_d;
  logic [WIDTH-1:0]    n_q, n_d, a_q, a_d, y_q, y_d;
  logic [EXP_BITS-1:0] e_q, e_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [1:0]          vfin_q, vfin_d;
  logic                ov_q, ov_d;
  logic [1:0]          ovd_q, ovd_d;
  logic [WIDTH-1:0]    ores_q, ores_d;

  logic                start;
  logic [WIDTH-1:0]    mplier, mcand, res, n_m1;
  logic                done;
  logic                cv  [WIDTH+1];
  logic [WIDTH-1:0]    cr  [WIDTH+1];

  assign cv[0] = start;
  assign cr[0] = '0;

  for (genvar i = 0; i < WIDTH; i++) begin : g_cell
    mrwt_cell #(.WIDTH(WIDTH)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(cv[i]),
      .acc_i  (cr[i]),
      .bit_i  (mplier[WIDTH-1-i]),
      .mcand_i(mcand),
      .mod_i  (n_q),
      .valid_o(cv[i+1]),
      .acc_o  (cr[i+1])
    );
  end

  assign done = cv[WIDTH];
  assign res  = cr[WIDTH];
  assign n_m1 = n_q - {{(WIDTH-1){1'b0}}, 1'b1};

  always_comb begin
    case (state_q)
      ST_RED: begin
        mplier = a_q;
        mcand  = {{(WIDTH-1){1'b0}}, 1'b1};
      end
      ST_SQ: begin
        mplier = y_q;
        mcand  = y_q;
      end
      default: begin
        mplier = y_q;
        mcand  = a_q;
      end
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d  = state_q;
    issued_d = issued_q;
    n_d      = n_q;
    a_d      = a_q;
    y_d      = y_q;
    e_d      = e_q;
    cnt_d    = cnt_q;
    vfin_d   = vfin_q;
    ov_d     = ov_q && !out_ready_i;
    ovd_d    = ovd_q;
    ores_d   = ores_q;
    start    = 1'b0;
    if ((state_q == ST_RED || state_q == ST_SQ || state_q == ST_MUL) && !issued_q) begin
      start    = 1'b1;
      issued_d = 1'b1;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          n_d   = modulus_i;
          a_d   = base_i;
          e_d   = exponent_i;
          y_d   = {{(WIDTH-1){1'b0}}, 1'b1};
          cnt_d = CW'(EXP_BITS - 1);
          if (modulus_i < WIDTH'(2)) begin
            vfin_d  = mrwt_pkg::VERDICT_INVALID;
            y_d     = '0;
            state_d = ST_FIN;
          end else begin
            state_d = ST_RED;
          end
        end
      end
      ST_RED: begin
        if (done) begin
          a_d      = res;
          issued_d = 1'b0;
          state_d  = ST_SQ;
        end
      end
      ST_SQ: begin
        if (done) begin
          issued_d = 1'b0;
          y_d      = res;
          if (res == {{(WIDTH-1){1'b0}}, 1'b1} && y_q != {{(WIDTH-1){1'b0}}, 1'b1}
              && y_q != n_m1) begin
            vfin_d  = mrwt_pkg::VERDICT_ROOT;
            state_d = ST_FIN;
          end else if (e_q[cnt_q]) begin
            state_d = ST_MUL;
          end else if (cnt_q == '0) begin
            vfin_d  = (res == {{(WIDTH-1){1'b0}}, 1'b1}) ? mrwt_pkg::VERDICT_PRIME
                                                         : mrwt_pkg::VERDICT_FERMAT;
            state_d = ST_FIN;
          end else begin
            cnt_d = cnt_q - 1'b1;
          end
        end
      end
      ST_MUL: begin
        if (done) begin
          issued_d = 1'b0;
          y_d      = res;
          if (cnt_q == '0) begin
            vfin_d  = (res == {{(WIDTH-1){1'b0}}, 1'b1}) ? mrwt_pkg::VERDICT_PRIME
                                                         : mrwt_pkg::VERDICT_FERMAT;
            state_d = ST_FIN;
          end else begin
            cnt_d   = cnt_q - 1'b1;
            state_d = ST_SQ;
          end
        end
      end
      ST_FIN: begin
        if (!ov_q || out_ready_i) begin
          ov_d    = 1'b1;
          ovd_d   = vfin_q;
          ores_d  = y_q;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      issued_q <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      issued_q <= issued_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    a_q    <= a_d;
    y_q    <= y_d;
    e_q    <= e_d;
    cnt_q  <= cnt_d;
    vfin_q <= vfin_d;
    ovd_q  <= ovd_d;
    ores_q <= ores_d;
  end

  assign out_valid_o = ov_q;
  assign verdict_o   = ovd_q;
  assign residue_o   = ores_q;

  a_done_issued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> issued_q)
    else $error("product left the cell row with no operation issued");

  a_start_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> !start)
    else $error("two operations launched back to back");

  a_y_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SQ || state_q == ST_MUL) |-> (y_q < n_q && a_q < n_q))
    else $error("operand not reduced below the modulus");

  a_root_residue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && ovd_q == mrwt_pkg::VERDICT_ROOT) |-> ores_q == {{(WIDTH-1){1'b0}}, 1'b1})
    else $error("square-root verdict without residue one");
endmodule

// File: test/mrwt_checker.sv
// Checker for the Miller-Rabin witness test: predicts verdicts and residues and compares.
`timescale 1ns / 1ps
module mrwt_checker #(
  parameter int WIDTH    = 16,
  parameter int EXP_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic [WIDTH-1:0]    modulus_i,
  input  logic [WIDTH-1:0]    base_i,
  input  logic [EXP_BITS-1:0] exponent_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic [1:0]          verdict_i,
  input  logic [WIDTH-1:0]    residue_i,
  output int                  errors_o,
  output int                  pending_o,
  output int                  results_o
);
  typedef struct packed {
    logic [1:0]       verdict;
    logic [WIDTH-1:0] residue;
  } witness_t;

  witness_t verdict_q[$];
  int       mismatches = 0;
  int       got = 0;

  function automatic witness_t witness_run(logic [WIDTH-1:0] n, logic [WIDTH-1:0] a,
                                           logic [EXP_BITS-1:0] x);
    witness_t         r;
    logic [63:0]      y;
    logic [63:0]      prev;
    r.verdict = mrwt_pkg::VERDICT_PRIME;
    y = 64'd1;
    if (n < 2) begin
      r.verdict = mrwt_pkg::VERDICT_INVALID;
      r.residue = '0;
      return r;
    end
    for (int b = EXP_BITS - 1; b >= 0; b--) begin
      prev = y;
      y = (y * y) % n;
      if (y == 1 && prev != 1 && prev != n - 1) begin
        r.verdict = mrwt_pkg::VERDICT_ROOT;
        break;
      end
      if (x[b]) y = (y * a) % n;
    end
    if (r.verdict != mrwt_pkg::VERDICT_ROOT && y != 1) r.verdict = mrwt_pkg::VERDICT_FERMAT;
    r.residue = y[WIDTH-1:0];
    return r;
  endfunction

  always @(posedge clk_i) begin
    witness_t w;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i)
        verdict_q = {verdict_q, witness_run(modulus_i, base_i, exponent_i)};
      if (out_valid_i && out_ready_i) begin
        got++;
        if (verdict_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result v=%0d r=%0d", verdict_i, residue_i);
        end else begin
          w = verdict_q.pop_front();
          if (w.verdict !== verdict_i || w.residue !== residue_i) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp v=%0d r=%0d got v=%0d r=%0d",
                       w.verdict, w.residue, verdict_i, residue_i);
          end
        end
      end
    end
  end

  assign errors_o  = mismatches;
  assign pending_o = verdict_q.size();
  assign results_o = got;
endmodule

// File: test/tb_miller_rabin_witness_test.sv
// Testbench top: stimulus, flow control and verdict for the witness test.
`timescale 1ns / 1ps
module tb_miller_rabin_witness_test;
  localparam int WIDTH = 16;
  localparam int EXP_BITS = 16;

  logic                clk_i = 0;
  logic                rst_ni = 0;
  logic                in_valid_i = 0;
  logic                in_ready_o;
  logic [WIDTH-1:0]    modulus_i = '0;
  logic [WIDTH-1:0]    base_i = '0;
  logic [EXP_BITS-1:0] exponent_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 0;
  logic [1:0]          verdict_o;
  logic [WIDTH-1:0]    residue_o;
  int                  errors, pending, results;
  int                  send_idle = 0, recv_stall = 0;
  bit                  hold_off = 0;
  int                  sent = 0;

  miller_rabin_witness_test #(.WIDTH(WIDTH), .EXP_BITS(EXP_BITS)) dut (.*);

  mrwt_checker #(.WIDTH(WIDTH), .EXP_BITS(EXP_BITS)) u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .modulus_i, .base_i,
    .exponent_i, .out_valid_i(out_valid_o), .out_ready_i, .verdict_i(verdict_o),
    .residue_i(residue_o), .errors_o(errors), .pending_o(pending), .results_o(results)
  );

  initial forever #6 clk_i = ~clk_i;

  always @(negedge clk_i)
    out_ready_i <= !hold_off && ($urandom_range(99) >= recv_stall);

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic offer(int n, int a, int x);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 0;
      @(negedge clk_i);
    end
    in_valid_i <= 1;
    modulus_i  <= WIDTH'(n);
    base_i     <= WIDTH'(a);
    exponent_i <= EXP_BITS'(x);
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent++;
    @(negedge clk_i);
  endtask

  task automatic random_item();
    int n;
    int a;
    n = $urandom;
    case ($urandom_range(9))
      0: offer(n, $urandom, $urandom);
      1: offer($urandom_range(3), $urandom, $urandom);
      2: offer(n | 1, $urandom, $urandom);
      default: begin
        n = (n & 'hfff) | 1;
        if (n < 3) n = 3;
        a = $urandom_range(n - 1, 1);
        offer(n, a, n - 1);
      end
    endcase
  endtask

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);
    offer(0, 5, 4);
    offer(1, 5, 4);
    offer(2, 1, 1);
    offer(3, 2, 2);
    offer(561, 2, 560);
    offer(561, 50, 560);
    offer(341, 2, 340);
    offer(65521, 3, 65520);
    offer(65535, 65535, 65535);
    offer(65535, 2, 'hffff);
    offer(97, 0, 96);
    offer(97, 5, 0);
    offer(97, 300, 96);
    offer(15, 4, 14);
    offer(65535, 'haaaa, 'h5555);
    offer('h8001, 'h5555, 'haaaa);
    offer(9, 8, 8);
    offer(1105, 2, 1104);
    for (int ph = 0; ph < 4; ph++) begin
      send_idle  = (ph == 1 || ph == 3) ? (ph == 1 ? 58 : 34) : 0;
      recv_stall = (ph == 2 || ph == 3) ? (ph == 2 ? 58 : 34) : 0;
      if (ph == 0) fork
        begin
          hold_off = 1;
          repeat (400) @(negedge clk_i);
          hold_off = 0;
        end
        repeat (4) random_item();
      join
      repeat (133) random_item();
    end
    in_valid_i <= 0;
    fork
      begin
        wait (pending == 0);
        repeat (600) @(posedge clk_i);
      end
      begin
        repeat (200000) @(posedge clk_i);
        $display("timeout waiting for results");
      end
    join_any
    $display("ran %0d witness tests, %0d results checked, under four flow-control mixes",
             sent, results);
    if (errors == 0 && pending == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #40ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
